// File: rtl/core/vdw_pkg.sv
// Package for the vertex dedup window: field widths and parameter defaults.
// No dependencies; compiled first.
`default_nettype none
package vdw_pkg;
	localparam int FIELD_BITS          = 24;
	localparam int MESH_BITS           = 8;
	localparam int VNUM_BITS           = 32;
	localparam int WINDOW_ENTRIES_DEF  = 16;
	localparam int INDEX_BITS_DEF      = 24;
endpackage
`default_nettype wire

// File: rtl/core/vdw_if.sv
// Valid/ready channel interfaces for face corners in and vertex words out.
// Depends on vdw_pkg for field widths.
`default_nettype none
interface vdw_corner_if;
	import vdw_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [FIELD_BITS-1:0] position_index;
	logic [FIELD_BITS-1:0] normal_index;
	logic [FIELD_BITS-1:0] texcoord_index;
	logic [MESH_BITS-1:0]  mesh_id;
	modport source (output valid, position_index, normal_index, texcoord_index, mesh_id,
		input ready);
	modport sink (input valid, position_index, normal_index, texcoord_index, mesh_id,
		output ready);
endinterface

interface vdw_vertex_if;
	import vdw_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [VNUM_BITS-1:0]  vertex_number;
	logic                  is_new;
	logic [FIELD_BITS-1:0] out_position_index;
	logic [FIELD_BITS-1:0] out_normal_index;
	logic [FIELD_BITS-1:0] out_texcoord_index;
	logic [MESH_BITS-1:0]  out_mesh_id;
	modport source (output valid, vertex_number, is_new, out_position_index,
		out_normal_index, out_texcoord_index, out_mesh_id, input ready);
	modport sink (input valid, vertex_number, is_new, out_position_index,
		out_normal_index, out_texcoord_index, out_mesh_id, output ready);
endinterface
`default_nettype wire

// File: rtl/core/vdw_cell.sv
// One window cell: holds a vertex triple, compares it against the broadcast key
// and hands its triple to the next older cell on a shift. Uses vdw_pkg.
`default_nettype none
module vdw_cell #(
	parameter int INDEX_BITS = vdw_pkg::INDEX_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    shift,
	input  wire logic [3*INDEX_BITS-1:0] key,
	input  wire logic [3*INDEX_BITS-1:0] prev_entry,
	output logic      [3*INDEX_BITS-1:0] entry,
	output logic                         match
);
	import vdw_pkg::*;

	logic [3*INDEX_BITS-1:0] entry_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			entry_q <= prev_entry;
		end
	end

	assign entry = entry_q;
	assign match = (entry_q == key);
endmodule
`default_nettype wire

// File: rtl/core/vertex_dedup_window.sv
// Vertex dedup window: one face corner is accepted per clock when the output
// word is taken (or the output register is empty). The corner's triple is matched in the
// same cycle against a chain of WINDOW_ENTRIES cells, newest in cell 0; a miss
// shifts the triple into cell 0, drops the oldest and takes the next vertex
// number, a hit returns counter - 1 - age. Results go out through the output
// register; the window starts empty after reset, with no clearing pass.
// Depends on vdw_pkg, vdw_if and vdw_cell.
`default_nettype none
module vertex_dedup_window #(
	parameter int WINDOW_ENTRIES = vdw_pkg::WINDOW_ENTRIES_DEF,
	parameter int INDEX_BITS     = vdw_pkg::INDEX_BITS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	vdw_corner_if.sink  corner,
	vdw_vertex_if.source vertex
);
	import vdw_pkg::*;

	localparam int AGE_W  = (WINDOW_ENTRIES > 1) ? $clog2(WINDOW_ENTRIES) : 1;
	localparam int FILL_W = $clog2(WINDOW_ENTRIES + 1);
	localparam int KEY_W  = 3 * INDEX_BITS;

	logic [INDEX_BITS-1:0] key_pos, key_nrm, key_tex;
	logic [KEY_W-1:0]      key;
	logic [KEY_W-1:0]      entries [WINDOW_ENTRIES];
	logic [WINDOW_ENTRIES-1:0] match_raw, match;
	logic                  hit;
	logic [AGE_W-1:0]      hit_age;
	logic                  accept, shift;
	logic [FILL_W-1:0]     fill_q;
	logic [VNUM_BITS-1:0]  counter_q;
	logic [VNUM_BITS-1:0]  vnum;

	logic                  out_valid_q;
	logic [VNUM_BITS-1:0]  vnum_q;
	logic                  is_new_q;
	logic [FIELD_BITS-1:0] pos_q, nrm_q, tex_q;
	logic [MESH_BITS-1:0]  mesh_q;

	assign key_pos = INDEX_BITS'(corner.position_index);
	assign key_nrm = INDEX_BITS'(corner.normal_index);
	assign key_tex = INDEX_BITS'(corner.texcoord_index);
	assign key     = {key_pos, key_nrm, key_tex};

	assign corner.ready = !out_valid_q || vertex.ready;
	assign accept       = corner.valid && corner.ready;
	assign shift        = accept && !hit;

	genvar gi;
	generate
		for (gi = 0; gi < WINDOW_ENTRIES; gi++) begin : g_cell
			vdw_cell #(.INDEX_BITS(INDEX_BITS)) u_cell (
				.clk        (clk),
				.shift      (shift),
				.key        (key),
				.prev_entry ((gi == 0) ? key : entries[(gi == 0) ? 0 : gi - 1]),
				.entry      (entries[gi]),
				.match      (match_raw[gi])
			);
			assign match[gi] = match_raw[gi] && (FILL_W'(gi) < fill_q);
		end
	endgenerate

	always_comb begin
		hit_age = '0;
		for (int i = WINDOW_ENTRIES - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_age = AGE_W'(i);
			end
		end
	end

	assign hit  = |match;
	assign vnum = hit ? (counter_q - VNUM_BITS'(1) - VNUM_BITS'(hit_age)) : counter_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			counter_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (shift) begin
				counter_q <= counter_q + VNUM_BITS'(1);
				if (fill_q != FILL_W'(WINDOW_ENTRIES)) begin
					fill_q <= fill_q + FILL_W'(1);
				end
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (vertex.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			vnum_q   <= vnum;
			is_new_q <= !hit;
			pos_q    <= FIELD_BITS'(key_pos);
			nrm_q    <= FIELD_BITS'(key_nrm);
			tex_q    <= FIELD_BITS'(key_tex);
			mesh_q   <= corner.mesh_id;
		end
	end

	assign vertex.valid              = out_valid_q;
	assign vertex.vertex_number      = vnum_q;
	assign vertex.is_new             = is_new_q;
	assign vertex.out_position_index = pos_q;
	assign vertex.out_normal_index   = nrm_q;
	assign vertex.out_texcoord_index = tex_q;
	assign vertex.out_mesh_id        = mesh_q;
endmodule
`default_nettype wire
